// ----- rtl/klpe_pkg.sv -----
// Shared types, codes and sizes for the keyed list pool engine.
package klpe_pkg;

    localparam int SLOTS         = 16;
    localparam int PAYLOAD_BYTES = 8;
    localparam int SLOT_W        = $clog2(SLOTS);
    localparam int IDX_W         = SLOT_W + 1;

    localparam int OP_W     = 2;
    localparam int KEY_W    = 32;
    localparam int LEN_W    = 4;
    localparam int WORD_W   = 64;
    localparam int STAT_W   = 2;
    localparam int SLOTO_W  = 4;
    localparam int CAP_W    = 5;
    localparam int CFG_W    = 5;
    localparam int CFG_IX_W = 1;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_LONG = 2'd2;
    localparam logic [STAT_W-1:0] STAT_MISS = 2'd3;

    localparam logic [CFG_IX_W-1:0] CFG_CAPACITY = 1'b0;
    localparam logic [CFG_IX_W-1:0] CFG_MAX_LEN  = 1'b1;

    localparam logic [IDX_W-1:0] NIL_IDX = IDX_W'(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_WRITE,
        S_INS_LINK,
        S_WALK,
        S_FINISH
    } state_t;

    // Keep the low len bytes of a payload word, zero the rest.
    function automatic logic [WORD_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            if (i < int'(len))
            begin
                m[8*i +: 8] = 8'hFF;
            end
        end
        return m;
    endfunction

endpackage

// ----- rtl/keyed_list_pool_engine_unit.sv -----
// Top level of the keyed list pool engine: sequencer, slot pool and list walker.
//
//  channel | signals                                     | direction
//  --------+---------------------------------------------+----------
//  input   | in_valid/in_ready, operation, key,          | in
//          | byte_count, data_word                       |
//  output  | out_valid/out_ready, status, slot,          | out
//          | result_key, found_len, found_word           |
//  config  | cfg_we, cfg_index, cfg_data                 | in
//
// One item at a time. Insert writes the new entry in S_INS_WRITE, then, when it
// succeeds and the list was not empty, writes the old tail link in S_INS_LINK.
// Delete and lookup walk the list in S_WALK, one slot key compare per cycle, over
// at most SLOTS entries up to the match or the end of the list; the unused code
// goes straight to S_FINISH. Input is ready again the cycle after the result loads.
// Reset: list empty, pool unused, capacity SLOTS, max_len 8; no clearing pass.
// A result waiting on out_ready does not block the next input transfer; only
// the final load into the output register waits for the output to drain.
module keyed_list_pool_engine_unit
    import klpe_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [OP_W-1:0]       operation,
    input  logic signed [KEY_W-1:0] key,
    input  logic [LEN_W-1:0]      byte_count,
    input  logic [WORD_W-1:0]     data_word,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [STAT_W-1:0]     status,
    output logic [SLOTO_W-1:0]    slot,
    output logic signed [KEY_W-1:0] result_key,
    output logic [LEN_W-1:0]      found_len,
    output logic [WORD_W-1:0]     found_word,

    input  logic                  cfg_we,
    input  logic [CFG_IX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    // Slot pool: one write per cycle on each array, one read address (the walker).
    logic [KEY_W-1:0]  slot_key_reg     [SLOTS];
    logic [LEN_W-1:0]  slot_len_reg     [SLOTS];
    logic [WORD_W-1:0] slot_payload_reg [SLOTS];
    logic [IDX_W-1:0]  slot_link_reg    [SLOTS];

    state_t            state_reg, state_next;

    // Latched input item.
    logic [OP_W-1:0]   op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [WORD_W-1:0] word_reg;

    // List bookkeeping.
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  tail_reg, tail_next;
    logic [IDX_W-1:0]  next_unused_reg, next_unused_next;
    logic [CAP_W-1:0]  capacity_reg;
    logic [LEN_W-1:0]  max_len_reg;

    // Walker.
    logic [IDX_W-1:0]  cur_reg, cur_next;
    logic [IDX_W-1:0]  prev_reg, prev_next;
    logic [IDX_W-1:0]  step_reg, step_next;

    // Staged result.
    logic [STAT_W-1:0]  res_status_reg, res_status_next;
    logic [SLOTO_W-1:0] res_slot_reg, res_slot_next;
    logic [LEN_W-1:0]   res_len_reg, res_len_next;
    logic [WORD_W-1:0]  res_word_reg, res_word_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  status_reg;
    logic [SLOTO_W-1:0] slot_reg;
    logic [KEY_W-1:0]   result_key_reg;
    logic [LEN_W-1:0]   found_len_reg;
    logic [WORD_W-1:0]  found_word_reg;

    // Pool write controls.
    logic               entry_we;
    logic [SLOT_W-1:0]  entry_addr;
    logic               link_we;
    logic [SLOT_W-1:0]  link_addr;
    logic [IDX_W-1:0]   link_data;
    logic               out_load;

    // Shared datapath terms.
    logic               in_xfer;
    logic [IDX_W-1:0]   cap_eff;
    logic               pool_full;
    logic               too_long;
    logic               walk_end;
    logic               key_hit;
    logic [SLOT_W-1:0]  cur_slot;

    assign in_xfer  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign cur_slot = cur_reg[SLOT_W-1:0];

    // Capacity above the pool size saturates to it.
    assign cap_eff   = (32'(capacity_reg) > SLOTS) ? NIL_IDX : IDX_W'(capacity_reg);
    assign pool_full = (next_unused_reg >= cap_eff);
    assign too_long  = (len_reg > max_len_reg) || (32'(len_reg) > PAYLOAD_BYTES);

    // The one compare unit of the walker: current slot key against the item key.
    assign walk_end = (cur_reg >= NIL_IDX) || (step_reg == NIL_IDX);
    assign key_hit  = (slot_key_reg[cur_slot] == key_reg);

    assign out_load = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    if (operation == OP_INSERT)
                        state_next = S_INS_WRITE;
                    else if (operation == OP_DELETE || operation == OP_LOOKUP)
                        state_next = S_WALK;
                    else
                        state_next = S_FINISH;
                end
            end
            S_INS_WRITE:
            begin
                if (pool_full || too_long || tail_reg == NIL_IDX)
                    state_next = S_FINISH;
                else
                    state_next = S_INS_LINK;
            end
            S_INS_LINK:
            begin
                state_next = S_FINISH;
            end
            S_WALK:
            begin
                if (walk_end || key_hit)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath controls and next values.
    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        next_unused_next = next_unused_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        step_next        = step_reg;
        res_status_next  = res_status_reg;
        res_slot_next    = res_slot_reg;
        res_len_next     = res_len_reg;
        res_word_next    = res_word_reg;
        entry_we         = 1'b0;
        entry_addr       = next_unused_reg[SLOT_W-1:0];
        link_we          = 1'b0;
        link_addr        = next_unused_reg[SLOT_W-1:0];
        link_data        = NIL_IDX;
        out_valid_next   = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                // Start every item as a miss; hold the walker at the head.
                cur_next        = head_reg;
                prev_next       = NIL_IDX;
                step_next       = '0;
                res_status_next = STAT_MISS;
                res_slot_next   = '0;
                res_len_next    = '0;
                res_word_next   = '0;
            end
            S_INS_WRITE:
            begin
                if (pool_full)
                begin
                    res_status_next = STAT_FULL;
                end
                else if (too_long)
                begin
                    res_status_next = STAT_LONG;
                end
                else
                begin
                    // Append: write the new entry, remember the old tail for linking.
                    entry_we         = 1'b1;
                    link_we          = 1'b1;
                    link_data        = NIL_IDX;
                    prev_next        = tail_reg;
                    tail_next        = next_unused_reg;
                    next_unused_next = next_unused_reg + 1'b1;
                    if (tail_reg == NIL_IDX)
                        head_next = next_unused_reg;
                    res_status_next  = STAT_OK;
                    res_slot_next    = SLOTO_W'(next_unused_reg);
                end
            end
            S_INS_LINK:
            begin
                link_we   = 1'b1;
                link_addr = prev_reg[SLOT_W-1:0];
                link_data = tail_reg;
            end
            S_WALK:
            begin
                if (!walk_end)
                begin
                    if (key_hit)
                    begin
                        res_status_next = STAT_OK;
                        res_slot_next   = SLOTO_W'(cur_reg);
                        if (op_reg == OP_LOOKUP)
                        begin
                            res_len_next  = slot_len_reg[cur_slot];
                            res_word_next = slot_payload_reg[cur_slot];
                        end
                        else
                        begin
                            // Unlink: bypass the hit in its predecessor or the head.
                            if (prev_reg == NIL_IDX)
                            begin
                                head_next = slot_link_reg[cur_slot];
                            end
                            else
                            begin
                                link_we   = 1'b1;
                                link_addr = prev_reg[SLOT_W-1:0];
                                link_data = slot_link_reg[cur_slot];
                            end
                            if (tail_reg == cur_reg)
                                tail_next = prev_reg;
                        end
                    end
                    else
                    begin
                        prev_next = cur_reg;
                        cur_next  = slot_link_reg[cur_slot];
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (out_load)
                    out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= NIL_IDX;
            tail_reg        <= NIL_IDX;
            next_unused_reg <= '0;
            capacity_reg    <= CAP_W'(SLOTS);
            max_len_reg     <= LEN_W'(PAYLOAD_BYTES);
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            next_unused_reg <= next_unused_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_CAPACITY: capacity_reg <= cfg_data[CAP_W-1:0];
                    CFG_MAX_LEN:  max_len_reg  <= cfg_data[LEN_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // Payload and walker registers.
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        prev_reg       <= prev_next;
        step_reg       <= step_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_len_reg    <= res_len_next;
        res_word_reg   <= res_word_next;
        if (in_xfer)
        begin
            op_reg   <= operation;
            key_reg  <= key;
            len_reg  <= byte_count;
            word_reg <= data_word;
        end
        if (state_reg == S_FINISH && out_load)
        begin
            status_reg     <= res_status_reg;
            slot_reg       <= res_slot_reg;
            result_key_reg <= key_reg;
            found_len_reg  <= res_len_reg;
            found_word_reg <= res_word_reg;
        end
    end

    // Slot pool writes.
    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            slot_key_reg[entry_addr]     <= key_reg;
            slot_len_reg[entry_addr]     <= len_reg;
            slot_payload_reg[entry_addr] <= word_reg & byte_mask(len_reg);
        end
        if (link_we)
        begin
            slot_link_reg[link_addr] <= link_data;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot       = slot_reg;
    assign result_key = result_key_reg;
    assign found_len  = found_len_reg;
    assign found_word = found_word_reg;

endmodule

// ----- rtl/klpe_checker.sv -----
// Port-level checks for the keyed list pool engine, bound to the top level.
module klpe_checker
    import klpe_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [STAT_W-1:0]     status,
    input logic [SLOTO_W-1:0]    slot,
    input logic signed [KEY_W-1:0] result_key,
    input logic [LEN_W-1:0]      found_len,
    input logic [WORD_W-1:0]     found_word
);

    // One item at a time: a transfer in drops ready on the next cycle.
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready held after a transfer");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(slot)
            && $stable(result_key) && $stable(found_len) && $stable(found_word))
        else $error("result changed while stalled");

    // A failed item reports slot zero and no payload.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> slot == '0 && found_len == '0 && found_word == '0)
        else $error("failed result carries slot or payload");

    // Stored lengths passed the insert check.
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(found_len) <= PAYLOAD_BYTES)
        else $error("found length beyond payload size");

endmodule

bind keyed_list_pool_engine_unit klpe_checker u_klpe_checker (.*);

// ----- tb/sv/tb_keyed_list_pool_engine_unit.sv -----
// Self-checking testbench for the keyed list pool engine: directed and random list traffic.
`timescale 1ns / 100ps

module tb_keyed_list_pool_engine_unit;
    import klpe_pkg::*;

    // The fourth operation code has no name in the package; the block ignores it.
    localparam logic [OP_W-1:0] OP_UNUSED   = 2'd3;
    localparam int              CYCLE_LIMIT = 400000;
    localparam int              SETTLE      = 4;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic [SLOTO_W-1:0]       slot;
        logic signed [KEY_W-1:0]  key;
        logic [LEN_W-1:0]         flen;
        logic [WORD_W-1:0]        fword;
    } list_result_t;

    // Clock, reset and block ports. Every input starts at a known value.
    logic                    clk;
    logic                    rst_n      = 1'b0;
    logic                    in_valid   = 1'b0;
    logic                    in_ready;
    logic [OP_W-1:0]         operation  = OP_INSERT;
    logic signed [KEY_W-1:0] key        = '0;
    logic [LEN_W-1:0]        byte_count = '0;
    logic [WORD_W-1:0]       data_word  = '0;
    logic                    out_valid;
    logic                    out_ready  = 1'b0;
    logic [STAT_W-1:0]       status;
    logic [SLOTO_W-1:0]      slot;
    logic signed [KEY_W-1:0] result_key;
    logic [LEN_W-1:0]        found_len;
    logic [WORD_W-1:0]       found_word;
    logic                    cfg_we     = 1'b0;
    logic [CFG_IX_W-1:0]     cfg_index  = CFG_CAPACITY;
    logic [CFG_W-1:0]        cfg_data   = '0;

    // Shadow of the list state and the two registers.
    logic [KEY_W-1:0]        pool_key  [SLOTS];
    logic [LEN_W-1:0]        pool_len  [SLOTS];
    logic [WORD_W-1:0]       pool_word [SLOTS];
    logic [IDX_W-1:0]        pool_link [SLOTS];
    logic [IDX_W-1:0]        list_head;
    logic [IDX_W-1:0]        list_tail;
    logic [IDX_W-1:0]        next_free;
    int                      cap_setting;
    int                      max_len_setting;

    // Results owed by the block, oldest first.
    list_result_t            list_results_due[$];

    int                      err_count       = 0;
    int                      cycle_count     = 0;
    int                      send_idle_pct   = 0;
    int                      recv_stall_pct  = 0;
    int                      hold_off_cycles = 0;

    keyed_list_pool_engine_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .key        (key),
        .byte_count (byte_count),
        .data_word  (data_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .slot       (slot),
        .result_key (result_key),
        .found_len  (found_len),
        .found_word (found_word),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Walk the shadow list from the head; return the first slot holding k (NIL if none)
    // and its predecessor (NIL when the match is the head).
    function automatic logic [IDX_W-1:0] walk_to_key(input logic [KEY_W-1:0] k,
                                                     output logic [IDX_W-1:0] prev);
        logic [IDX_W-1:0] cur;
        cur  = list_head;
        prev = NIL_IDX;
        for (int s = 0; s < SLOTS && cur != NIL_IDX; s++)
        begin
            if (pool_key[cur[SLOT_W-1:0]] == k)
            begin
                return cur;
            end
            prev = cur;
            cur  = pool_link[cur[SLOT_W-1:0]];
        end
        prev = NIL_IDX;
        return NIL_IDX;
    endfunction

    // Apply one operation to the shadow list and return the result the block owes for it.
    function automatic list_result_t predict_list_op(input logic [OP_W-1:0] op,
                                                     input logic [KEY_W-1:0] k,
                                                     input logic [LEN_W-1:0] len,
                                                     input logic [WORD_W-1:0] word);
        list_result_t     r;
        logic [IDX_W-1:0] hit;
        logic [IDX_W-1:0] prev;
        logic [IDX_W-1:0] after;
        logic [WORD_W-1:0] keep;
        int               eff_cap;
        int               n;
        eff_cap  = (cap_setting > SLOTS) ? SLOTS : cap_setting;
        r.status = STAT_MISS;
        r.slot   = '0;
        r.key    = k;
        r.flen   = '0;
        r.fword  = '0;
        case (op)
            OP_INSERT:
            begin
                // Full is checked first, so it wins over an overlong payload.
                if (int'(next_free) >= eff_cap)
                begin
                    r.status = STAT_FULL;
                end
                else if (int'(len) > max_len_setting || int'(len) > PAYLOAD_BYTES)
                begin
                    r.status = STAT_LONG;
                end
                else
                begin
                    n    = int'(next_free);
                    keep = (int'(len) >= 8) ? '1 : ((64'd1 << (8 * int'(len))) - 64'd1);
                    pool_key[n]  = k;
                    pool_len[n]  = len;
                    pool_word[n] = word & keep;
                    pool_link[n] = NIL_IDX;
                    if (list_tail != NIL_IDX)
                    begin
                        pool_link[list_tail[SLOT_W-1:0]] = IDX_W'(n);
                    end
                    else
                    begin
                        list_head = IDX_W'(n);
                    end
                    list_tail = IDX_W'(n);
                    next_free = IDX_W'(n + 1);
                    r.status  = STAT_OK;
                    r.slot    = SLOTO_W'(n);
                end
            end
            OP_DELETE:
            begin
                hit = walk_to_key(k, prev);
                if (hit != NIL_IDX)
                begin
                    after = pool_link[hit[SLOT_W-1:0]];
                    if (prev != NIL_IDX)
                    begin
                        pool_link[prev[SLOT_W-1:0]] = after;
                    end
                    else
                    begin
                        list_head = after;
                    end
                    // Unlinking the tail pulls the tail back to the predecessor;
                    // for a sole entry that is NIL, so the list is empty again.
                    if (list_tail == hit)
                    begin
                        list_tail = prev;
                    end
                    r.status = STAT_OK;
                    r.slot   = hit[SLOTO_W-1:0];
                end
            end
            OP_LOOKUP:
            begin
                hit = walk_to_key(k, prev);
                if (hit != NIL_IDX)
                begin
                    r.status = STAT_OK;
                    r.slot   = hit[SLOTO_W-1:0];
                    r.flen   = pool_len[hit[SLOT_W-1:0]];
                    r.fword  = pool_word[hit[SLOT_W-1:0]];
                end
            end
            default:
            begin
                // Unused code: no state change, reported as a miss.
            end
        endcase
        return r;
    endfunction

    // Offer one item, hold it until the transfer, then record what it owes.
    // Valid is only lowered when a gap is taken, never dropped and re-raised in one step.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k,
                             input logic [LEN_W-1:0] len, input logic [WORD_W-1:0] word);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        key        <= k;
        byte_count <= len;
        data_word  <= word;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        list_results_due.push_back(predict_list_op(op, k, len, word));
    endtask

    // Drop valid and let every owed result drain, then give the block a few idle cycles.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        while (list_results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    // Register write, only ever issued with the block idle.
    task automatic write_reg(input logic [CFG_IX_W-1:0] idx, input int value);
        wait_until_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_CAPACITY)
        begin
            cap_setting = value & 31;
        end
        else
        begin
            max_len_setting = value & 15;
        end
    endtask

    // Lookups and deletes on an empty list miss; the unused code is ignored.
    task automatic test_empty_list();
        send_item(OP_LOOKUP, 32'h0000_0000, 4'd0, 64'd0);
        send_item(OP_DELETE, 32'hFFFF_FFFF, 4'd0, 64'd0);
        send_item(OP_UNUSED, 32'h7FFF_FFFF, 4'd15, '1);
    endtask

    // Zero capacity, full beating too-long, a sole entry inserted and deleted.
    task automatic test_capacity_limits();
        write_reg(CFG_CAPACITY, 0);
        send_item(OP_INSERT, 32'd5, 4'd3, 64'h1122_3344_5566_7788);
        send_item(OP_INSERT, 32'd5, 4'd12, 64'h1122_3344_5566_7788);
        write_reg(CFG_CAPACITY, 1);
        write_reg(CFG_MAX_LEN, 0);
        send_item(OP_INSERT, 32'd6, 4'd1, 64'hFF);
        send_item(OP_INSERT, 32'h8000_0000, 4'd0, '1);
        send_item(OP_INSERT, 32'd7, 4'd0, 64'd0);
        send_item(OP_LOOKUP, 32'h8000_0000, 4'd0, 64'd0);
        send_item(OP_DELETE, 32'h8000_0000, 4'd0, 64'd0);
        send_item(OP_LOOKUP, 32'h8000_0000, 4'd0, 64'd0);
    endtask

    // Capacity above the pool saturates; lengths beyond the payload word are rejected
    // even when max_len allows them; short payloads are masked.
    task automatic test_payload_limits();
        write_reg(CFG_CAPACITY, 31);
        write_reg(CFG_MAX_LEN, 15);
        send_item(OP_INSERT, 32'd9, 4'd9, '1);
        send_item(OP_INSERT, 32'd9, 4'd15, '1);
        send_item(OP_INSERT, 32'h7FFF_FFFF, 4'd8, '1);
        send_item(OP_INSERT, 32'hFFFF_FFFF, 4'd3, 64'h0123_4567_89AB_CDEF);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 4'd0, 64'd0);
    endtask

    // Duplicate keys, unlink of head, tail and a middle entry, then capacity under use.
    task automatic test_unlink_cases();
        send_item(OP_INSERT, 32'h7FFF_FFFF, 4'd1, 64'hA5A5_A5A5_A5A5_A5A5);
        send_item(OP_LOOKUP, 32'h7FFF_FFFF, 4'd0, 64'd0);
        send_item(OP_DELETE, 32'h7FFF_FFFF, 4'd0, 64'd0);
        send_item(OP_LOOKUP, 32'h7FFF_FFFF, 4'd0, 64'd0);
        send_item(OP_DELETE, 32'h7FFF_FFFF, 4'd0, 64'd0);
        send_item(OP_INSERT, 32'd0, 4'd8, 64'hFEDC_BA98_7654_3210);
        send_item(OP_INSERT, 32'd1, 4'd2, 64'h5A5A);
        send_item(OP_DELETE, 32'd0, 4'd0, 64'd0);
        send_item(OP_LOOKUP, 32'd1, 4'd0, 64'd0);
        write_reg(CFG_CAPACITY, 3);
        send_item(OP_INSERT, 32'd2, 4'd1, 64'h1);
    endtask

    // Random traffic, mostly hits on live keys; ignored items do not count.
    task automatic test_random_traffic(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int               done_items;
        int               roll;
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] k;
        logic [LEN_W-1:0] len;
        logic [KEY_W-1:0] live_keys[$];
        logic [IDX_W-1:0] cur;
        done_items     = 0;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        while (done_items < n_items)
        begin
            live_keys.delete();
            cur = list_head;
            while (cur != NIL_IDX)
            begin
                live_keys.push_back(pool_key[cur[SLOT_W-1:0]]);
                cur = pool_link[cur[SLOT_W-1:0]];
            end
            roll = $urandom_range(99);
            op   = (roll < 12) ? OP_INSERT : (roll < 55) ? OP_LOOKUP :
                   (roll < 95) ? OP_DELETE : OP_UNUSED;
            // Favor keys already in the list, then a narrow band that collides often.
            roll = $urandom_range(99);
            if (live_keys.size() > 0 && roll < 55)
            begin
                k = live_keys[$urandom_range(live_keys.size() - 1)];
            end
            else if (roll < 80)
            begin
                k = 32'($urandom_range(7)) - 32'd2;
            end
            else
            begin
                k = $urandom();
            end
            len = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
            send_item(op, k, len, {$urandom(), $urandom()});
            if (op != OP_UNUSED)
            begin
                done_items++;
            end
        end
    endtask

    // Hold the output off for a long stretch while the sender keeps offering,
    // so the block fills and stalls its input.
    task automatic test_backpressure();
        write_reg(CFG_CAPACITY, 16);
        write_reg(CFG_MAX_LEN, 8);
        hold_off_cycles <= 300;
        test_random_traffic(40, 0, 0);
    endtask

    // Receiver: a long hold-off when asked, otherwise random stalls at the current rate.
    always @(posedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            out_ready       <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare every output transfer against the oldest owed result.
    always @(posedge clk)
    begin : check_results
        list_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (list_results_due.size() == 0)
            begin
                $display("%0t: unexpected result: status %0d slot %0d key %0h", $time,
                         status, slot, result_key);
                err_count++;
            end
            else
            begin
                want = list_results_due.pop_front();
                if (status !== want.status)
                begin
                    $display("%0t: status: expected %0d, actual %0d", $time,
                             want.status, status);
                    err_count++;
                end
                if (slot !== want.slot)
                begin
                    $display("%0t: slot: expected %0d, actual %0d", $time, want.slot, slot);
                    err_count++;
                end
                if (result_key !== want.key)
                begin
                    $display("%0t: result_key: expected %0h, actual %0h", $time,
                             want.key, result_key);
                    err_count++;
                end
                if (found_len !== want.flen)
                begin
                    $display("%0t: found_len: expected %0d, actual %0d", $time,
                             want.flen, found_len);
                    err_count++;
                end
                if (found_word !== want.fword)
                begin
                    $display("%0t: found_word: expected %0h, actual %0h", $time,
                             want.fword, found_word);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: end the run if the traffic ever hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_keyed_list_pool_engine_unit: done, errors");
            $finish;
        end
    end

    initial
    begin
        // Shadow state after reset: empty list, nothing handed out, default registers.
        list_head       = NIL_IDX;
        list_tail       = NIL_IDX;
        next_free       = '0;
        cap_setting     = SLOTS;
        max_len_setting = 8;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_capacity_limits();
        test_payload_limits();
        test_unlink_cases();

        // Random phases, each under its own register setting and idling pattern.
        write_reg(CFG_CAPACITY, 16);
        write_reg(CFG_MAX_LEN, 8);
        test_random_traffic(250, 0, 0);
        write_reg(CFG_CAPACITY, 20);
        write_reg(CFG_MAX_LEN, 4);
        test_random_traffic(250, 67, 0);
        write_reg(CFG_CAPACITY, 1);
        write_reg(CFG_MAX_LEN, 15);
        test_random_traffic(250, 0, 67);
        write_reg(CFG_CAPACITY, 16);
        write_reg(CFG_MAX_LEN, 0);
        test_random_traffic(250, 30, 30);
        test_backpressure();

        wait_until_idle();
        repeat (30) @(posedge clk);
        if (err_count == 0)
        begin
            $display("tb_keyed_list_pool_engine_unit: done, clean");
        end
        else
        begin
            $display("tb_keyed_list_pool_engine_unit: done, errors");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/klpe_pkg.sv
rtl/keyed_list_pool_engine_unit.sv
rtl/klpe_checker.sv
tb/sv/tb_keyed_list_pool_engine_unit.sv
